[rtl/awsq_pkg.sv]
// Shared constants, register codes and record types of the saturation qualifier.
package awsq_pkg;

  localparam int NodesDefault     = 8;
  localparam int RingDepthDefault = 16;

  localparam int NodeFieldW = 3;
  localparam int SlotW      = 4;
  localparam int BwW        = 32;
  localparam int MemW       = 48;
  localparam int ThrW       = 7;
  localparam int WinW       = 3;
  localparam int CfgIdxW    = 2;

  localparam int PctScale = 100;

  localparam logic [ThrW-1:0] ThrReset    = ThrW'(90);
  localparam logic [WinW-1:0] MaxWinReset = WinW'(4);

  typedef enum logic [CfgIdxW-1:0] {
    CFG_BW_THR  = 2'd0,
    CFG_CAP_THR = 2'd1,
    CFG_MAX_WIN = 2'd2
  } awsq_cfg_e;

  // Per node and kind qualifier record.
  typedef struct packed {
    logic [WinW-1:0] win_log2;
    logic            reported;
  } awsq_ctrl_t;

  typedef struct packed {
    logic [NodeFieldW-1:0] node;
    logic                  kind;
    logic                  saturated;
    logic                  changed;
  } awsq_result_t;

endpackage

[rtl/awsq_sat_detect.sv]
// Raw saturation bit: operand stage, product stage, then threshold compares.
module awsq_sat_detect (
  input  logic                     clk_i,
  input  logic                     load_i,
  input  logic                     kind_i,
  input  logic [awsq_pkg::BwW-1:0]  bw_cur_a_i,
  input  logic [awsq_pkg::BwW-1:0]  bw_max_a_i,
  input  logic [awsq_pkg::BwW-1:0]  bw_cur_b_i,
  input  logic [awsq_pkg::BwW-1:0]  bw_max_b_i,
  input  logic [awsq_pkg::MemW-1:0] mem_total_i,
  input  logic [awsq_pkg::MemW-1:0] mem_free_i,
  input  logic                     mem_known_i,
  input  logic [awsq_pkg::ThrW-1:0] bw_thr_i,
  input  logic [awsq_pkg::ThrW-1:0] cap_thr_i,
  output logic                     sat_bit_o
);
  import awsq_pkg::*;

  localparam int BwPW  = BwW + ThrW;
  localparam int MemPW = MemW + ThrW;

  // Operand stage.
  logic            kind_q;
  logic [BwW-1:0]  cur_a_q, max_a_q, cur_b_q, max_b_q;
  logic [MemW-1:0] used_q, total_q;
  logic            cap_ok_q, a_live_q, b_live_q;

  // Product stage.
  logic             kind2_q, cap_ok2_q, a_live2_q, b_live2_q;
  logic [BwPW-1:0]  cur_a_x_q, max_a_x_q, cur_b_x_q, max_b_x_q;
  logic [MemPW-1:0] used_x_q, total_x_q;

  logic cmp_a, cmp_b, cmp_cap;

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      kind_q   <= kind_i;
      cur_a_q  <= bw_cur_a_i;
      max_a_q  <= bw_max_a_i;
      cur_b_q  <= bw_cur_b_i;
      max_b_q  <= bw_max_b_i;
      total_q  <= mem_total_i;
      // free above total counts as nothing used
      used_q   <= (mem_free_i >= mem_total_i) ? '0 : mem_total_i - mem_free_i;
      cap_ok_q <= mem_known_i && (mem_total_i != '0);
      a_live_q <= (bw_max_a_i != '0);
      b_live_q <= (bw_max_b_i != '0);
    end
  end

  always_ff @(posedge clk_i) begin
    kind2_q   <= kind_q;
    cap_ok2_q <= cap_ok_q;
    a_live2_q <= a_live_q;
    b_live2_q <= b_live_q;
    cur_a_x_q <= BwPW'(cur_a_q) * BwPW'(PctScale);
    max_a_x_q <= BwPW'(max_a_q) * BwPW'(bw_thr_i);
    cur_b_x_q <= BwPW'(cur_b_q) * BwPW'(PctScale);
    max_b_x_q <= BwPW'(max_b_q) * BwPW'(bw_thr_i);
    used_x_q  <= MemPW'(used_q) * MemPW'(PctScale);
    total_x_q <= MemPW'(total_q) * MemPW'(cap_thr_i);
  end

  assign cmp_a   = cur_a_x_q > max_a_x_q;
  assign cmp_b   = cur_b_x_q > max_b_x_q;
  assign cmp_cap = used_x_q > total_x_q;

  // Type 1 decides first: idle stops, saturated stops, else fall back to type 0.
  assign sat_bit_o = kind2_q ? (cap_ok2_q && cmp_cap)
                             : (b_live2_q && (cmp_b || (a_live2_q && cmp_a)));

endmodule

[rtl/awsq_hist_store.sv]
// History ring rows and qualifier records, one row per node and kind.
module awsq_hist_store #(
  parameter int ROW_W      = 4,
  parameter int RING_DEPTH = awsq_pkg::RingDepthDefault
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   rd_en_i,
  input  logic [ROW_W-1:0]       rd_addr_i,
  output logic [RING_DEPTH-1:0]  ring_o,
  output awsq_pkg::awsq_ctrl_t   ctrl_o,
  input  logic                   wr_en_i,
  input  logic [ROW_W-1:0]       wr_addr_i,
  input  logic [RING_DEPTH-1:0]  ring_wr_i,
  input  awsq_pkg::awsq_ctrl_t   ctrl_wr_i
);
  import awsq_pkg::*;

  localparam int Rows = 1 << ROW_W;

  logic [RING_DEPTH-1:0] ring_mem [Rows];
  awsq_ctrl_t            ctrl_mem [Rows];
  logic [Rows-1:0]       row_valid_q;

  logic [RING_DEPTH-1:0] ring_rd_q;
  awsq_ctrl_t            ctrl_rd_q;
  logic                  rd_valid_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      ring_mem[wr_addr_i] <= ring_wr_i;
      ctrl_mem[wr_addr_i] <= ctrl_wr_i;
    end
    if (rd_en_i) begin
      ring_rd_q <= ring_mem[rd_addr_i];
      ctrl_rd_q <= ctrl_mem[rd_addr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_valid_q <= '0;
      rd_valid_q  <= 1'b0;
    end else begin
      if (wr_en_i) begin
        row_valid_q[wr_addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_valid_q <= row_valid_q[rd_addr_i];
      end
    end
  end

  // Unwritten rows read as the reset state: empty ring, window of one, idle.
  assign ring_o = rd_valid_q ? ring_rd_q : '0;
  assign ctrl_o = rd_valid_q ? ctrl_rd_q : '0;

endmodule

[rtl/awsq_window_qual.sv]
// Window agreement check and window update for one history row.
module awsq_window_qual #(
  parameter int RING_DEPTH = awsq_pkg::RingDepthDefault
) (
  input  logic [RING_DEPTH-1:0]     ring_i,
  input  awsq_pkg::awsq_ctrl_t      ctrl_i,
  input  logic [awsq_pkg::SlotW-1:0] slot_i,
  input  logic [awsq_pkg::WinW-1:0]  ring_log2_i,
  input  logic                      bit_i,
  output logic [RING_DEPTH-1:0]     ring_o,
  output awsq_pkg::awsq_ctrl_t      ctrl_o,
  output logic                      changed_o
);
  import awsq_pkg::*;

  localparam int RingW = $clog2(RING_DEPTH);

  logic [RingW:0]          len;
  logic [RingW-1:0]        len_m1;
  logic [RingW-1:0]        head;
  logic [WinW-1:0]         wl_eff;
  logic [RingW:0]          win;
  logic [RING_DEPTH-1:0]   in_win;
  logic                    agree;
  logic                    state;

  assign len    = (RingW+1)'(1) << ring_log2_i;
  assign len_m1 = RingW'(len - (RingW+1)'(1));
  assign head   = RingW'(slot_i) & len_m1;
  assign wl_eff = (ctrl_i.win_log2 > ring_log2_i) ? ring_log2_i : ctrl_i.win_log2;
  assign win    = (RingW+1)'(1) << wl_eff;

  // Mark the older entries of the window, walking back from head in the ring in use.
  always_comb begin
    logic [RingW-1:0] age;
    age    = '0;
    in_win = '0;
    for (int j = 0; j < RING_DEPTH; j++) begin
      age       = (head - RingW'(j)) & len_m1;
      in_win[j] = (RingW'(j) <= len_m1) && (age != '0) && ((RingW+1)'(age) < win);
    end
  end

  assign agree = ~|(in_win & (ring_i ^ {RING_DEPTH{bit_i}}));

  always_comb begin
    ring_o       = ring_i;
    ring_o[head] = bit_i;
  end

  always_comb begin
    if (agree) begin
      ctrl_o.win_log2 = (wl_eff < ring_log2_i) ? wl_eff + WinW'(1) : wl_eff;
      state           = bit_i;
    end else begin
      ctrl_o.win_log2 = (wl_eff != '0) ? wl_eff - WinW'(1) : wl_eff;
      state           = ctrl_i.reported;
    end
    ctrl_o.reported = state;
  end

  assign changed_o = state ^ ctrl_i.reported;

endmodule

[rtl/adaptive_window_saturation_qualifier.sv]
// Top level of the adaptive window saturation qualifier.
//
// Usage:
//   Input channel (in_valid_i / in_ready_o) takes one sample word per node and
//   kind: bandwidth pairs for kind 0, total/free/known for kind 1, and the
//   ring slot of this sampling period. Every accepted word yields exactly one
//   result word on the output channel (out_valid_o / out_ready_i) carrying
//   the node, kind, qualified saturated state, changed flag and available.
//   Configuration writes (cfg_valid_i / cfg_ready_o, cfg_index_i, cfg_data_i)
//   are always taken; write them only while no sample is in flight.
// Timing:
//   One word at a time. A word passes through accept (operands latched,
//   history row read), products, compare plus read-modify-write of the row,
//   and the push into the output register. The output register frees the
//   input side, so the next word can be accepted while a result waits; no
//   word is accepted until the one before it has been pushed.
// Reset:
//   Thresholds return to 90 percent and the window limit to 16. Per-row valid
//   bits clear at once, so every history row reads as empty with no sweep.
// Stall:
//   A stalled receiver holds the result; the next word finishes its update and
//   waits in the push step until the output register drains.
module adaptive_window_saturation_qualifier #(
  parameter int NODES      = awsq_pkg::NodesDefault,
  parameter int RING_DEPTH = awsq_pkg::RingDepthDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [awsq_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [awsq_pkg::ThrW-1:0]      cfg_data_i,
  // sample input
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [awsq_pkg::NodeFieldW-1:0] node_i,
  input  logic                          kind_i,
  input  logic [awsq_pkg::SlotW-1:0]     slot_i,
  input  logic [awsq_pkg::BwW-1:0]       bw_cur_a_i,
  input  logic [awsq_pkg::BwW-1:0]       bw_max_a_i,
  input  logic [awsq_pkg::BwW-1:0]       bw_cur_b_i,
  input  logic [awsq_pkg::BwW-1:0]       bw_max_b_i,
  input  logic [awsq_pkg::MemW-1:0]      mem_total_i,
  input  logic [awsq_pkg::MemW-1:0]      mem_free_i,
  input  logic                          mem_known_i,
  // result output
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [awsq_pkg::NodeFieldW-1:0] out_node_o,
  output logic                          out_kind_o,
  output logic                          saturated_o,
  output logic                          changed_o,
  output logic                          available_o
);
  import awsq_pkg::*;

  localparam int NodeLimit   = 1 << NodeFieldW;
  localparam int NodeRows    = (NODES < NodeLimit) ? NODES : NodeLimit;
  localparam int NodeW       = (NodeRows > 1) ? $clog2(NodeRows) : 1;
  localparam int RowW        = NodeW + 1;
  localparam int RingLog2Max = $clog2(RING_DEPTH + 1) - 1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_MUL,
    S_EVAL,
    S_PUSH
  } st_e;

  st_e st_q;

  // configuration registers
  logic [ThrW-1:0] bw_thr_q, cap_thr_q;
  logic [WinW-1:0] max_win_q;
  logic [WinW-1:0] ring_log2;

  // sample bookkeeping
  logic                  in_accept;
  logic [NodeFieldW-1:0] node_q;
  logic                  kind_q;
  logic [SlotW-1:0]      slot_q;
  logic [RowW-1:0]       rd_row, row_q;
  logic                  node_ok;

  logic                  sat_bit;
  logic [RING_DEPTH-1:0] ring_rd, ring_wr;
  awsq_ctrl_t            ctrl_rd, ctrl_wr;
  logic                  qual_changed;
  logic                  wr_en;

  awsq_result_t res_d, res_q, out_res_q;
  logic         out_valid_q;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (st_q == S_IDLE);
  assign in_accept   = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bw_thr_q  <= ThrReset;
      cap_thr_q <= ThrReset;
      max_win_q <= MaxWinReset;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_BW_THR:  bw_thr_q  <= cfg_data_i;
        CFG_CAP_THR: cap_thr_q <= cfg_data_i;
        CFG_MAX_WIN: max_win_q <= cfg_data_i[WinW-1:0];
        default: ;  // drop writes past the register list
      endcase
    end
  end

  // Ring length in use: the window limit, clipped to what the ring holds.
  assign ring_log2 = (max_win_q > WinW'(RingLog2Max)) ? WinW'(RingLog2Max) : max_win_q;

  assign rd_row = {kind_i, node_i[NodeW-1:0]};

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      node_q <= node_i;
      kind_q <= kind_i;
      slot_q <= slot_i;
      row_q  <= rd_row;
    end
  end

  assign node_ok = (32'(node_q) < NODES);

  awsq_sat_detect u_detect (
    .clk_i       (clk_i),
    .load_i      (in_accept),
    .kind_i      (kind_i),
    .bw_cur_a_i  (bw_cur_a_i),
    .bw_max_a_i  (bw_max_a_i),
    .bw_cur_b_i  (bw_cur_b_i),
    .bw_max_b_i  (bw_max_b_i),
    .mem_total_i (mem_total_i),
    .mem_free_i  (mem_free_i),
    .mem_known_i (mem_known_i),
    .bw_thr_i    (bw_thr_q),
    .cap_thr_i   (cap_thr_q),
    .sat_bit_o   (sat_bit)
  );

  // Row read issues on accept and is held in the read register until the update
  // step consumes it; only one word is in flight, so read and write never overlap.
  awsq_hist_store #(
    .ROW_W      (RowW),
    .RING_DEPTH (RING_DEPTH)
  ) u_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (in_accept),
    .rd_addr_i (rd_row),
    .ring_o    (ring_rd),
    .ctrl_o    (ctrl_rd),
    .wr_en_i   (wr_en),
    .wr_addr_i (row_q),
    .ring_wr_i (ring_wr),
    .ctrl_wr_i (ctrl_wr)
  );

  awsq_window_qual #(
    .RING_DEPTH (RING_DEPTH)
  ) u_qual (
    .ring_i      (ring_rd),
    .ctrl_i      (ctrl_rd),
    .slot_i      (slot_q),
    .ring_log2_i (ring_log2),
    .bit_i       (sat_bit),
    .ring_o      (ring_wr),
    .ctrl_o      (ctrl_wr),
    .changed_o   (qual_changed)
  );

  // An out-of-range node leaves all state alone and reports available.
  assign wr_en = (st_q == S_EVAL) && node_ok;

  always_comb begin
    res_d.node      = node_q;
    res_d.kind      = kind_q;
    res_d.saturated = node_ok && ctrl_wr.reported;
    res_d.changed   = node_ok && qual_changed;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= S_IDLE;
      out_valid_q <= 1'b0;
      out_res_q   <= '0;
      res_q       <= '0;
    end else begin
      // the push step reloads the register itself
      if (out_valid_q && out_ready_i && st_q != S_PUSH) begin
        out_valid_q <= 1'b0;
      end
      unique case (st_q)
        S_IDLE: begin
          if (in_valid_i) begin
            st_q <= S_MUL;
          end
        end
        S_MUL: begin
          st_q <= S_EVAL;
        end
        S_EVAL: begin
          res_q <= res_d;
          st_q  <= S_PUSH;
        end
        S_PUSH: begin
          // hold until the output register is free or draining
          if (!out_valid_q || out_ready_i) begin
            out_valid_q <= 1'b1;
            out_res_q   <= res_q;
            st_q        <= S_IDLE;
          end
        end
        default: st_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_node_o  = out_res_q.node;
  assign out_kind_o  = out_res_q.kind;
  assign saturated_o = out_res_q.saturated;
  assign changed_o   = out_res_q.changed;
  assign available_o = ~out_res_q.saturated;

`ifndef SYNTH
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> !in_ready_o)
    else $error("second word accepted while one is in flight");

  a_push_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == S_PUSH && !out_valid_q) |=> out_valid_q)
    else $error("push step did not load a free output register");

  a_change_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (changed_o || saturated_o)) |-> (32'(out_node_o) < NODES))
    else $error("state reported for a node outside the configured range");

  a_no_write_out_of_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == S_EVAL && !(32'(node_q) < NODES)) |-> !wr_en)
    else $error("history written for a node outside the configured range");
`endif

endmodule
